// ===== src/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg
// shared types and constants of the section address translator
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

   // default depth of the section table
   localparam int MAX_SECTIONS_DEFAULT = 16;

   // field widths fixed by the interface
   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 5;
   localparam int SLOT_IN_W = 4;
   localparam int CSR_IDX_W = 1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_SIZE   = 1'b0,
      CSR_SECTION_COUNT = 1'b1
   } csr_index_type;

   // result status codes
   typedef enum logic [1:0] {
      RS_HEADER   = 2'd0,
      RS_FOUND    = 2'd1,
      RS_NO_MATCH = 2'd2
   } status_type;

   // one stored section entry
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] raw;
   } entry_type;

   // outcome of checking one entry against an address
   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] offset;
   } match_type;

endpackage : sat_pkg

`default_nettype wire

// ===== src/sat_entry_match.sv =====
// ----------------------------------------------------------------------------
// sat_entry_match
// range check of one section entry and the file offset it gives
// ----------------------------------------------------------------------------
`default_nettype none

module sat_entry_match (
   input  sat_pkg::entry_type          entry,
   input  logic [sat_pkg::ADDR_W-1:0]  address,
   output sat_pkg::match_type          result
);
   import sat_pkg::*;

   logic [ADDR_W:0]   range_end;
   logic              above_start;
   logic              below_end;

   // end of range kept at full width so it never wraps
   assign range_end   = {1'b0, entry.start} + {1'b0, entry.length};
   assign above_start = address >= entry.start;
   assign below_end   = {1'b0, address} < range_end;

   assign result.hit    = above_start && below_end;
   assign result.offset = entry.raw + (address - entry.start);

endmodule : sat_entry_match

`default_nettype wire

// ===== src/section_address_translator.sv =====
// ----------------------------------------------------------------------------
// section_address_translator
// relative virtual address to file offset translation over a section table
// ----------------------------------------------------------------------------
// usage
//   req_ channel: a load transaction (req_mode 0) writes the start, length and
//   raw position of one section into slot req_section_slot; it gives no result.
//   a translate transaction (req_mode 1) gives exactly one rsp_ transaction
//   with file offset, status and matched slot.
//   csr_ channel: index 0 is the header size, index 1 the section count; it is
//   always ready. write it only while no transaction is in flight; not enforced.
// table and scan
//   the section table sits in one synchronous memory, one entry read a cycle.
//   a translate stops at its first check when the address lies in the headers
//   or the count is zero; otherwise it scans the first min(count, MAX_SECTIONS)
//   entries in order up to the first match, one entry per cycle with the next
//   read issued while the current entry is checked. one transaction at a time.
// reset
//   synchronous, active high; clears the control state and both registers.
//   table contents are undefined until loaded.
// back-pressure
//   the result sits in an output register; a new transaction is taken while it
//   waits. a scan that finishes while that register is still full holds.
// ----------------------------------------------------------------------------
`default_nettype none

module section_address_translator #(
   parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // input transactions
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [sat_pkg::SLOT_IN_W-1:0]  req_section_slot,
   input  logic [sat_pkg::ADDR_W-1:0]     req_section_virtual_start,
   input  logic [sat_pkg::ADDR_W-1:0]     req_section_virtual_length,
   input  logic [sat_pkg::ADDR_W-1:0]     req_section_raw_position,
   input  logic [sat_pkg::ADDR_W-1:0]     req_relative_address,
   // result transactions
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sat_pkg::ADDR_W-1:0]     rsp_file_offset,
   output logic [1:0]                     rsp_status,
   output logic [sat_pkg::SLOT_IN_W-1:0]  rsp_matched_slot,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sat_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sat_pkg::ADDR_W-1:0]     csr_data
);
   import sat_pkg::*;

   // table address width, and a compare width that holds both the count
   // field and the table depth itself
   localparam int SLOT_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CMP_W  = (SLOT_W + 1 > COUNT_W) ? SLOT_W + 1 : COUNT_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   // control state
   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       header_size_ff;
   logic [COUNT_W-1:0]      section_count_ff;

   // scan datapath
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic [ADDR_W-1:0]       addr_ff;

   // result register
   logic [ADDR_W-1:0]       rsp_offset_ff, rsp_offset_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SLOT_IN_W-1:0]    rsp_slot_ff, rsp_slot_in;

   // section table: one entry per slot, read data registered
   entry_type               entry_mem_ff [MAX_SECTIONS];
   entry_type               entry_rd_ff;
   entry_type               wr_entry;
   logic [SLOT_W-1:0]       rd_addr;
   logic [SLOT_W-1:0]       wr_addr;
   logic                    wr_en;

   logic                    req_fire;
   logic                    csr_fire;
   logic                    out_free;
   logic [CMP_W-1:0]        count_ext;
   logic [CMP_W-1:0]        depth_c;
   logic [CMP_W-1:0]        limit;
   logic [CMP_W-1:0]        idx_next;
   logic                    in_header;
   logic                    last_entry;
   logic                    scan_done;
   logic                    slot_ok;
   match_type               match;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // --------------------------------------------------------------------------
   // configuration registers
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         header_size_ff   <= '0;
         section_count_ff <= '0;
      end else if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER_SIZE:   header_size_ff   <= csr_data;
            CSR_SECTION_COUNT: section_count_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // section table memory
   // --------------------------------------------------------------------------
   // slots beyond the table depth are dropped
   assign depth_c = CMP_W'(MAX_SECTIONS);
   assign slot_ok = CMP_W'(req_section_slot) < depth_c;
   assign wr_en   = req_fire && !req_mode && slot_ok;
   assign wr_addr = SLOT_W'(req_section_slot);

   assign wr_entry.start  = req_section_virtual_start;
   assign wr_entry.length = req_section_virtual_length;
   assign wr_entry.raw    = req_section_raw_position;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      entry_rd_ff <= entry_mem_ff[rd_addr];
   end

   // --------------------------------------------------------------------------
   // scan control
   // --------------------------------------------------------------------------
   // entries searched: the count, saturated at the table depth
   assign count_ext = CMP_W'(section_count_ff);
   assign limit     = (count_ext > depth_c) ? depth_c : count_ext;
   assign idx_next  = CMP_W'(idx_ff) + CMP_W'(1);

   assign in_header  = addr_ff < header_size_ff;
   assign last_entry = idx_next >= limit;

   sat_entry_match u_match (
      .entry   (entry_rd_ff),
      .address (addr_ff),
      .result  (match)
   );

   assign scan_done = in_header || (limit == '0) || match.hit || last_entry;

   // read ahead one entry while the current one is checked; hold the
   // current entry while a finished scan waits for the output register
   always_comb begin
      rd_addr = '0;
      if (state_ff == S_SCAN) begin
         if (scan_done) begin
            rd_addr = idx_ff;
         end else begin
            rd_addr = idx_next[SLOT_W-1:0];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_mode) begin
               // entry 0 is being read at this edge
               state_in = S_SCAN;
               idx_in   = '0;
            end
         end
         S_SCAN: begin
            if (!scan_done) begin
               idx_in = idx_next[SLOT_W-1:0];
            end else if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (in_header) begin
                  rsp_offset_in = addr_ff;
                  rsp_status_in = RS_HEADER;
                  rsp_slot_in   = '0;
               end else if ((limit != '0) && match.hit) begin
                  rsp_offset_in = match.offset;
                  rsp_status_in = RS_FOUND;
                  rsp_slot_in   = SLOT_IN_W'(idx_ff);
               end else begin
                  rsp_offset_in = '0;
                  rsp_status_in = RS_NO_MATCH;
                  rsp_slot_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      if (req_fire) begin
         addr_ff <= req_relative_address;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_file_offset  = rsp_offset_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_matched_slot = rsp_slot_ff;

   // --------------------------------------------------------------------------
   // assertions
   // --------------------------------------------------------------------------
   // the scan never runs past the searched entries
   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && (limit != '0) |-> (CMP_W'(idx_ff) < limit))
      else $error("scan index beyond searched entries");

   // a translate transaction always starts a scan
   a_translate_scans : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_mode |=> (state_ff == S_SCAN))
      else $error("translate transaction did not start a scan");

   // a load transaction never produces a result
   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_mode && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("load transaction produced a result");

   // no-match results carry zero offset and slot
   a_no_match_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == RS_NO_MATCH)
         |-> (rsp_offset_ff == '0) && (rsp_slot_ff == '0))
      else $error("no-match result with non-zero payload");

   // a result only appears at the end of a scan
   a_result_from_scan : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_SCAN))
      else $error("result loaded outside a scan");

endmodule : section_address_translator

`default_nettype wire

// ===== tb/sv/sat_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_tb_pkg
// expected-offset tracking for the section address translator testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sat_tb_pkg;

   import sat_pkg::*;

   localparam int TABLE_DEPTH = MAX_SECTIONS_DEFAULT;

   // request kinds carried on req_mode
   localparam logic MODE_LOAD      = 1'b0;
   localparam logic MODE_TRANSLATE = 1'b1;

   // one translation outcome
   typedef struct packed {
      logic [ADDR_W-1:0]    offset;
      status_type           status;
      logic [SLOT_IN_W-1:0] slot;
   } translation_type;

   class translation_tracker;

      logic [ADDR_W-1:0]  header_size;
      logic [COUNT_W-1:0] section_count;
      logic [ADDR_W-1:0]  start_tab  [TABLE_DEPTH];
      logic [ADDR_W-1:0]  length_tab [TABLE_DEPTH];
      logic [ADDR_W-1:0]  raw_tab    [TABLE_DEPTH];

      translation_type awaited[$];

      int unsigned errors;
      int unsigned loads;
      int unsigned header_hits;
      int unsigned section_hits;
      int unsigned misses;

      function new();
         header_size   = '0;
         section_count = '0;
         errors        = 0;
         loads         = 0;
         header_hits   = 0;
         section_hits  = 0;
         misses        = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [ADDR_W-1:0] data);
         case (idx)
            CSR_HEADER_SIZE: begin
               header_size = data;
            end
            CSR_SECTION_COUNT: begin
               section_count = data[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // entries actually searched, saturating at the table depth
      function int unsigned scan_limit();
         if (section_count > COUNT_W'(TABLE_DEPTH)) begin
            return TABLE_DEPTH;
         end
         return int'(section_count);
      endfunction

      function translation_type translate(logic [ADDR_W-1:0] addr);
         translation_type t;
         logic [ADDR_W:0] lo;
         logic [ADDR_W:0] hi;
         int unsigned     i;
         t.offset = '0;
         t.status = RS_NO_MATCH;
         t.slot   = '0;
         if (addr < header_size) begin
            t.offset = addr;
            t.status = RS_HEADER;
            return t;
         end
         for (i = 0; i < scan_limit(); i++) begin
            // range end kept at 33 bits so it never wraps
            lo = {1'b0, start_tab[i]};
            hi = lo + {1'b0, length_tab[i]};
            if ({1'b0, addr} >= lo && {1'b0, addr} < hi) begin
               t.offset = raw_tab[i] + addr - start_tab[i];
               t.status = RS_FOUND;
               t.slot   = i[SLOT_IN_W-1:0];
               return t;
            end
         end
         return t;
      endfunction

      function void note_request(logic mode, logic [SLOT_IN_W-1:0] slot,
                                 logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] length,
                                 logic [ADDR_W-1:0] raw, logic [ADDR_W-1:0] addr);
         if (mode == MODE_LOAD) begin
            start_tab[slot]  = start;
            length_tab[slot] = length;
            raw_tab[slot]    = raw;
            loads++;
         end else begin
            awaited.push_back(translate(addr));
         end
      endfunction

      function void mismatch(string field, logic [ADDR_W-1:0] exp, logic [ADDR_W-1:0] act);
         errors++;
         if (errors <= 60) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp, act);
         end
      endfunction

      function void check_result(logic [ADDR_W-1:0] offset, logic [1:0] status,
                                 logic [SLOT_IN_W-1:0] slot);
         translation_type exp;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 60) begin
               $display("%0t: unexpected result: offset %h status %0d slot %0d",
                        $time, offset, status, slot);
            end
            return;
         end
         exp = awaited.pop_front();
         case (exp.status)
            RS_HEADER: begin
               header_hits++;
            end
            RS_FOUND: begin
               section_hits++;
            end
            default: begin
               misses++;
            end
         endcase
         if (offset !== exp.offset) begin
            mismatch("file_offset", exp.offset, offset);
         end
         if (status !== exp.status) begin
            mismatch("status", ADDR_W'(exp.status), ADDR_W'(status));
         end
         if (slot !== exp.slot) begin
            mismatch("matched_slot", ADDR_W'(exp.slot), ADDR_W'(slot));
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

   endclass

endpackage : sat_tb_pkg

// ===== tb/sv/section_address_translator_test.sv =====
// ----------------------------------------------------------------------------
// section_address_translator_test
// loads section tables and translates addresses under random flow control,
// checking every result against an independent prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module section_address_translator_test;

   import sat_pkg::*;
   import sat_tb_pkg::*;

   // random transactions after the directed part
   localparam int RANDOM_ITEMS = 800;
   // quiet cycles before a register write, covers the longest scan
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
   // overall cycle limit, a guard against a hung run
   localparam int LIMIT_CYCLES = 500_000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic [SLOT_IN_W-1:0] req_section_slot;
   logic [ADDR_W-1:0]    req_section_virtual_start;
   logic [ADDR_W-1:0]    req_section_virtual_length;
   logic [ADDR_W-1:0]    req_section_raw_position;
   logic [ADDR_W-1:0]    req_relative_address;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [ADDR_W-1:0]    rsp_file_offset;
   logic [1:0]           rsp_status;
   logic [SLOT_IN_W-1:0] rsp_matched_slot;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_data;

   translation_tracker tracker = new();

   // idling controls, changed per phase
   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned stall_left    = 0;
   int unsigned cycle_count   = 0;
   int unsigned settings_run  = 0;

   section_address_translator uut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_mode                   (req_mode),
      .req_section_slot           (req_section_slot),
      .req_section_virtual_start  (req_section_virtual_start),
      .req_section_virtual_length (req_section_virtual_length),
      .req_section_raw_position   (req_section_raw_position),
      .req_relative_address       (req_relative_address),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_file_offset            (rsp_file_offset),
      .rsp_status                 (rsp_status),
      .rsp_matched_slot           (rsp_matched_slot),
      .csr_valid                  (csr_valid),
      .csr_ready                  (csr_ready),
      .csr_index                  (csr_index),
      .csr_data                   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // cycle limit guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: cycle limit reached, %0d results outstanding", $time, tracker.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: ready with random stall bursts, one assignment per edge
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall_pct > 0 && $urandom_range(99) < rsp_stall_pct) begin
            stall_left = $urandom_range(13, 1) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // result monitor: values read at the edge are the ones the handshake saw
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_result(rsp_file_offset, rsp_status, rsp_matched_slot);
      end
   end

   // present one request transaction and hold it until accepted; valid stays
   // high afterwards so that a back-to-back transaction needs no toggle
   task automatic send_req(logic mode, logic [SLOT_IN_W-1:0] slot, logic [ADDR_W-1:0] start,
                           logic [ADDR_W-1:0] length, logic [ADDR_W-1:0] raw,
                           logic [ADDR_W-1:0] addr);
      req_valid                  <= 1'b1;
      req_mode                   <= mode;
      req_section_slot           <= slot;
      req_section_virtual_start  <= start;
      req_section_virtual_length <= length;
      req_section_raw_position   <= raw;
      req_relative_address       <= addr;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(mode, slot, start, length, raw, addr);
   endtask

   task automatic pause_req(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold the sender until every awaited result has arrived
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // drain results, then give a trailing load time to complete
   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, data);
   endtask

   // registers are only touched with the block idle
   task automatic configure(logic [ADDR_W-1:0] hdr, logic [ADDR_W-1:0] count_word);
      settle();
      write_csr(CSR_HEADER_SIZE, hdr);
      write_csr(CSR_SECTION_COUNT, count_word);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   task automatic translate(logic [ADDR_W-1:0] addr);
      // unused section fields carry noise
      send_req(MODE_TRANSLATE, SLOT_IN_W'($urandom), $urandom, $urandom, $urandom, addr);
   endtask

   function automatic logic [ADDR_W-1:0] pick_start();
      case ($urandom_range(9))
         4, 5: begin
            return $urandom_range(32'hFFFF);
         end
         6, 7: begin
            // near the top, so start plus length runs past 2^32
            return 32'hFFFF_FFFF - $urandom_range(32'hFFFF);
         end
         8: begin
            return '0;
         end
         9: begin
            return $urandom & 32'hFFFF_F000;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_length();
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         1, 2, 3, 4: begin
            return $urandom_range(4096, 1);
         end
         5, 6: begin
            return $urandom_range(32'h00FF_FFFF, 1);
         end
         8: begin
            return 32'hFFFF_FFFF;
         end
         9: begin
            return $urandom | 32'h8000_0000;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic load_random_section(logic [SLOT_IN_W-1:0] slot);
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] l;
      logic [ADDR_W-1:0] r;
      int unsigned       src;
      if ($urandom_range(4) == 0) begin
         // overlap another entry so that first-match order matters
         src = $urandom_range(TABLE_DEPTH - 1);
         s   = tracker.start_tab[src] + ($urandom_range(1) ? 32'h0 : $urandom_range(255));
         l   = tracker.length_tab[src];
      end else begin
         s = pick_start();
         l = pick_length();
      end
      case ($urandom_range(9))
         0: begin
            r = '0;
         end
         1: begin
            r = 32'hFFFF_FFFF;
         end
         default: begin
            r = $urandom;
         end
      endcase
      send_req(MODE_LOAD, slot, s, l, r, $urandom);
   endtask

   // addresses aimed at sections, their edges and the header boundary
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned       i;
      int unsigned       limit;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] l;
      logic [ADDR_W-1:0] h;
      limit = tracker.scan_limit();
      h     = tracker.header_size;
      i     = (limit > 0) ? $urandom_range(limit - 1) : $urandom_range(TABLE_DEPTH - 1);
      s     = tracker.start_tab[i];
      l     = tracker.length_tab[i];
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7: begin
            return (l == 0) ? s : s + ($urandom % l);
         end
         8, 9: begin
            return s;
         end
         10: begin
            return s + l - 1;
         end
         11: begin
            return s + l;
         end
         12: begin
            return s - 1;
         end
         13, 14: begin
            return (h == 0) ? 32'h0 : $urandom % h;
         end
         15: begin
            return h - 1;
         end
         16: begin
            return h;
         end
         17: begin
            return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   initial begin : stimulus
      int unsigned       k;
      int unsigned       n;
      int unsigned       random_items;
      bit                last_phase;
      logic [ADDR_W-1:0] hdr;
      logic [COUNT_W-1:0] cnt;
      logic [ADDR_W-1:0] count_word;

      random_items = 0;
      req_valid                  <= 1'b0;
      req_mode                   <= MODE_LOAD;
      req_section_slot           <= '0;
      req_section_virtual_start  <= '0;
      req_section_virtual_length <= '0;
      req_section_raw_position   <= '0;
      req_relative_address       <= '0;
      csr_valid                  <= 1'b0;
      csr_index                  <= CSR_HEADER_SIZE;
      csr_data                   <= '0;
      reset                      <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty search, then a crafted table
      configure(32'h0, 32'h0);
      translate(32'h0);
      translate(32'hFFFF_FFFF);

      send_req(MODE_LOAD, 4'd0, 32'h0000_1000, 32'h0000_0200, 32'h0000_0400, $urandom);
      // overlaps slot 0, only wins past its end
      send_req(MODE_LOAD, 4'd1, 32'h0000_1100, 32'h0000_1000, 32'h0000_8000, $urandom);
      // range end beyond 2^32, must not wrap
      send_req(MODE_LOAD, 4'd2, 32'hFFFF_F000, 32'h0000_2000, 32'h0000_0010, $urandom);
      // empty section never matches
      send_req(MODE_LOAD, 4'd3, 32'h0000_5000, 32'h0000_0000, 32'h0000_0001, $urandom);
      for (k = 4; k < TABLE_DEPTH - 1; k++) begin
         send_req(MODE_LOAD, SLOT_IN_W'(k), pick_start(), pick_length(), $urandom, $urandom);
      end
      // catch-all in the last slot, offset wraps modulo 2^32
      send_req(MODE_LOAD, 4'd15, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FF00, $urandom);

      configure(32'h0000_0800, 32'd16);
      translate(32'h0000_07FF);
      translate(32'h0000_0800);
      translate(32'h0000_1150);
      translate(32'h0000_1200);
      translate(32'hFFFF_FFFF);
      translate(32'h0000_5000);

      // count above depth saturates; upper data bits are noise
      configure(32'hFFFF_FFFF, 32'hA5A5_A5BF);
      translate(32'hFFFF_FFFE);
      translate(32'hFFFF_FFFF);

      // random phases, each under its own register setting and flow control
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(5))
            1: begin
               hdr = 32'hFFFF_FFFF;
            end
            2: begin
               hdr = $urandom_range(32'hFFF);
            end
            3: begin
               hdr = $urandom;
            end
            4: begin
               hdr = tracker.start_tab[$urandom_range(TABLE_DEPTH - 1)];
            end
            default: begin
               hdr = '0;
            end
         endcase
         case ($urandom_range(7))
            0: begin
               cnt = '0;
            end
            1: begin
               cnt = 5'd1;
            end
            2, 3: begin
               cnt = 5'd16;
            end
            4: begin
               cnt = COUNT_W'($urandom_range(31, 17));
            end
            default: begin
               cnt = COUNT_W'($urandom_range(15, 2));
            end
         endcase
         count_word = {{(ADDR_W - COUNT_W){1'b0}}, cnt};
         if ($urandom_range(2) == 0) begin
            count_word = ($urandom & 32'hFFFF_FFE0) | count_word;
         end
         configure(hdr, count_word);

         n          = $urandom_range(110, 60);
         last_phase = (random_items + n >= RANDOM_ITEMS);
         if (last_phase) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            case ($urandom_range(3))
               0: req_gap_pct = 0;
               1: req_gap_pct = 10;
               2: req_gap_pct = 25;
               default: req_gap_pct = 40;
            endcase
            case ($urandom_range(3))
               0: rsp_stall_pct = 0;
               1: rsp_stall_pct = 10;
               2: rsp_stall_pct = 25;
               default: rsp_stall_pct = 40;
            endcase
         end

         for (k = 0; k < n; k++) begin
            if (req_gap_pct > 0 && $urandom_range(99) < req_gap_pct) begin
               pause_req($urandom_range(13, 1));
            end else if (!last_phase && $urandom_range(99) < 3) begin
               wait_results();
            end
            if ($urandom_range(99) < 15) begin
               load_random_section(SLOT_IN_W'($urandom_range(TABLE_DEPTH - 1)));
            end else begin
               translate(pick_address());
            end
            random_items++;
         end
      end

      settle();
      $display("covered %0d section loads and %0d translations over %0d register settings",
               tracker.loads, tracker.header_hits + tracker.section_hits + tracker.misses,
               settings_run);
      $display("outcomes: %0d inside headers, %0d found in a section, %0d with no match",
               tracker.header_hits, tracker.section_hits, tracker.misses);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule : section_address_translator_test
